// ===== hdl/pxs_pkg.sv =====
// Shared constants, codes and types of the packet XOR scrambler.
package pxs_pkg;

	localparam int PACKET_MAX = 2048;
	localparam int MASK_MAX   = 32;

	localparam int DATA_W  = 8;
	localparam int POS_W   = 11;
	localparam int LEN_W   = 12;
	localparam int MLEN_W  = 6;
	localparam int MIDX_W  = 5;
	localparam int MASK_W  = 256;
	localparam int REG_W   = 64;
	localparam int ADDR_W  = 6;
	localparam int DIV_W   = POS_W + MLEN_W;

	localparam logic [LEN_W-1:0] MIRROR_MIN = LEN_W'(2);

	localparam logic [2:0] METHOD_PLAIN = 3'd0;
	localparam logic [2:0] METHOD_MASK  = 3'd1;
	localparam logic [2:0] METHOD_XPOS  = 3'd2;
	localparam logic [2:0] METHOD_REV   = 3'd3;
	localparam logic [2:0] METHOD_OBF   = 3'd4;

	localparam logic [2:0] REG_METHOD   = 3'd0;
	localparam logic [2:0] REG_OUTBOUND = 3'd1;
	localparam logic [2:0] REG_KEY_LEN  = 3'd2;
	localparam logic [2:0] REG_MASK0    = 3'd3;
	localparam logic [2:0] REG_MASK1    = 3'd4;
	localparam logic [2:0] REG_MASK2    = 3'd5;
	localparam logic [2:0] REG_MASK3    = 3'd6;

	typedef struct packed {
		logic [2:0]        method;
		logic              outbound;
		logic [MLEN_W-1:0] key_len;
		logic [MASK_W-1:0] mask;
	} pxs_cfg_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [POS_W-1:0]  dest;
		logic [POS_W-1:0]  mpos;
		logic              use_mask;
		logic              bad;
	} pxs_item_t;

endpackage

// ===== hdl/pxs_regs.sv =====
// Configuration register file behind the APB-style port.
module pxs_regs import pxs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready,
	output pxs_cfg_t          cfg
);

	logic [2:0]        method_q;
	logic              outbound_q;
	logic [MLEN_W-1:0] key_length_q;
	logic [MASK_W-1:0] mask_q;
	logic              wr;
	logic [2:0]        idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q      <= METHOD_PLAIN;
			outbound_q    <= 1'b0;
			key_length_q  <= MLEN_W'(1);
			mask_q        <= '0;
		end else if (wr) begin
			case (idx)
				REG_METHOD:   method_q           <= pwdata[2:0];
				REG_OUTBOUND: outbound_q         <= pwdata[0];
				REG_KEY_LEN:  key_length_q       <= pwdata[MLEN_W-1:0];
				REG_MASK0:    mask_q[63:0]       <= pwdata;
				REG_MASK1:    mask_q[127:64]     <= pwdata;
				REG_MASK2:    mask_q[191:128]    <= pwdata;
				REG_MASK3:    mask_q[255:192]    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_METHOD:   prdata = REG_W'(method_q);
			REG_OUTBOUND: prdata = REG_W'(outbound_q);
			REG_KEY_LEN:  prdata = REG_W'(key_length_q);
			REG_MASK0:    prdata = mask_q[63:0];
			REG_MASK1:    prdata = mask_q[127:64];
			REG_MASK2:    prdata = mask_q[191:128];
			REG_MASK3:    prdata = mask_q[255:192];
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		cfg.method   = method_q;
		cfg.outbound = outbound_q;
		cfg.key_len  = (32'(key_length_q) > MASK_MAX) ? MLEN_W'(MASK_MAX) : key_length_q;
		cfg.mask     = mask_q;
	end

endmodule

// ===== hdl/pxs_front.sv =====
// First stage: range check, mirror position and position XOR terms.
module pxs_front import pxs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pxs_cfg_t          cfg,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [DATA_W-1:0] data_byte,
	input  logic [POS_W-1:0]  position,
	input  logic [LEN_W-1:0]  packet_length,
	output logic              valid_s1,
	output pxs_item_t         item_s1,
	input  logic              en_next
);

	pxs_item_t         nxt;
	logic              bad;
	logic              rev;
	logic [LEN_W-1:0]  diff;
	logic [POS_W-1:0]  p;
	logic [DATA_W-1:0] i1;
	logic [DATA_W-1:0] p1;
	logic              en;

	assign en         = !valid_s1 || en_next;
	assign item_ready = en;

	always_comb begin
		bad  = ({1'b0, position} >= packet_length) || (32'(packet_length) > PACKET_MAX);
		rev  = (cfg.method == METHOD_REV) || (cfg.method == METHOD_OBF);
		diff = packet_length - {1'b0, position};
		p    = (rev && packet_length > MIRROR_MIN && position != '0) ? diff[POS_W-1:0]
		                                                           : position;
		i1   = position[DATA_W-1:0] + DATA_W'(1);
		p1   = p[DATA_W-1:0] + DATA_W'(1);

		nxt.data     = data_byte;
		nxt.dest     = position;
		nxt.mpos     = position;
		nxt.use_mask = 1'b0;
		nxt.bad      = bad;
		if (!bad) begin
			case (cfg.method)
				METHOD_MASK: begin
					nxt.use_mask = (cfg.key_len != '0);
				end
				METHOD_XPOS: begin
					nxt.data = data_byte ^ i1;
				end
				METHOD_REV: begin
					nxt.dest = p;
				end
				METHOD_OBF: begin
					nxt.dest     = p;
					nxt.data     = data_byte ^ i1 ^ p1;
					nxt.mpos     = cfg.outbound ? p : position;
					nxt.use_mask = (cfg.key_len != '0);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt;
		end
	end

endmodule

// ===== hdl/pxs_mod_stage.sv =====
// Pipeline stage of the mask index remainder: STEP_CNT restoring subtract steps.
module pxs_mod_stage import pxs_pkg::*; #(
	parameter int STEP_HI  = 10,
	parameter int STEP_CNT = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pxs_cfg_t  cfg,
	input  logic      valid_in,
	input  pxs_item_t item_in,
	output logic      en,
	output logic      valid_sn,
	output pxs_item_t item_sn,
	input  logic      en_next
);

	pxs_item_t        nxt;
	logic [DIV_W-1:0] r;
	logic [DIV_W-1:0] d;

	assign en = !valid_sn || en_next;

	always_comb begin
		nxt = item_in;
		r   = DIV_W'(item_in.mpos);
		for (int s = 0; s < STEP_CNT; s++) begin
			d = DIV_W'(cfg.key_len) << (STEP_HI - s);
			if (r >= d) begin
				r = r - d;
			end
		end
		nxt.mpos = r[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_sn <= nxt;
		end
	end

endmodule

// ===== hdl/pxs_out.sv =====
// Last stage: mask byte lookup, final XOR and the output register.
module pxs_out import pxs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pxs_cfg_t          cfg,
	input  logic              valid_in,
	input  pxs_item_t         item_in,
	output logic              en,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [DATA_W-1:0] result_byte,
	output logic [POS_W-1:0]  dest_position,
	output logic              bad_position
);

	logic              valid_s5;
	logic [DATA_W-1:0] byte_s5;
	logic [POS_W-1:0]  dest_s5;
	logic              bad_s5;
	logic [MIDX_W-1:0] idx;
	logic [DATA_W-1:0] mbyte;

	assign en    = !valid_s5 || result_ready;
	assign idx   = item_in.mpos[MIDX_W-1:0];
	assign mbyte = cfg.mask[{idx, 3'b000} +: DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byte_s5 <= item_in.use_mask ? (item_in.data ^ mbyte) : item_in.data;
			dest_s5 <= item_in.dest;
			bad_s5  <= item_in.bad;
		end
	end

	assign result_valid  = valid_s5;
	assign result_byte   = byte_s5;
	assign dest_position = dest_s5;
	assign bad_position  = bad_s5;

endmodule

// ===== hdl/packet_xor_scramble.sv =====
// Top level of the per-byte packet XOR scrambler.
// Five register stages, three of them for the mask index remainder.
// Throughput: one byte per cycle while the output is not stalled by result_ready.
// A stalled output holds its stage; upstream stages keep filling bubbles.
// Reset clears all valid bits and the registers (key length to 1).
module packet_xor_scramble import pxs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [DATA_W-1:0] data_byte,
	input  logic [POS_W-1:0]  position,
	input  logic [LEN_W-1:0]  packet_length,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [DATA_W-1:0] result_byte,
	output logic [POS_W-1:0]  dest_position,
	output logic              bad_position
);

	pxs_cfg_t  cfg;
	logic      valid_s1, valid_s2, valid_s3, valid_s4;
	pxs_item_t item_s1, item_s2, item_s3, item_s4;
	logic      en_s2, en_s3, en_s4, en_s5;

	pxs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pxs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.data_byte     (data_byte),
		.position      (position),
		.packet_length (packet_length),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.en_next       (en_s2)
	);

	pxs_mod_stage #(.STEP_HI(10), .STEP_CNT(4)) u_mod_s2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_in (valid_s1),
		.item_in  (item_s1),
		.en       (en_s2),
		.valid_sn (valid_s2),
		.item_sn  (item_s2),
		.en_next  (en_s3)
	);

	pxs_mod_stage #(.STEP_HI(6), .STEP_CNT(4)) u_mod_s3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_in (valid_s2),
		.item_in  (item_s2),
		.en       (en_s3),
		.valid_sn (valid_s3),
		.item_sn  (item_s3),
		.en_next  (en_s4)
	);

	pxs_mod_stage #(.STEP_HI(2), .STEP_CNT(3)) u_mod_s4 (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_in (valid_s3),
		.item_in  (item_s3),
		.en       (en_s4),
		.valid_sn (valid_s4),
		.item_sn  (item_s4),
		.en_next  (en_s5)
	);

	pxs_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.valid_in      (valid_s4),
		.item_in       (item_s4),
		.en            (en_s5),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_byte   (result_byte),
		.dest_position (dest_position),
		.bad_position  (bad_position)
	);

endmodule

// ===== tb/tb_packet_xor_scramble.sv =====
// Self-checking testbench for the packet XOR scrambler: APB setup, random traffic, scoreboard.
module tb_packet_xor_scramble;
	import pxs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 9;
	localparam int SETTLE       = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 4000;
	localparam int PHASE_ITEMS  = 45;

	localparam logic [2:0] METHOD_SPARE = 3'd7;

	typedef struct packed {
		logic [DATA_W-1:0] out_byte;
		logic [POS_W-1:0]  dest;
		logic              bad;
	} scrambled_byte_t;

	class scramble_scoreboard;
		logic [2:0]        method;
		logic              outbound;
		logic [MLEN_W-1:0] key_len;
		logic [REG_W-1:0]  mask_word [4];
		scrambled_byte_t   expected_q [$];
		int                accepted;
		int                checked;
		int                flagged;
		int                errors;

		function void reset_regs();
			method   = METHOD_PLAIN;
			outbound = 1'b0;
			key_len  = MLEN_W'(1);
			foreach (mask_word[k])
				mask_word[k] = '0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [REG_W-1:0] value);
			case (idx)
				REG_METHOD:   method = value[2:0];
				REG_OUTBOUND: outbound = value[0];
				REG_KEY_LEN:  key_len = value[MLEN_W-1:0];
				REG_MASK0:    mask_word[0] = value;
				REG_MASK1:    mask_word[1] = value;
				REG_MASK2:    mask_word[2] = value;
				REG_MASK3:    mask_word[3] = value;
				default: ;
			endcase
		endfunction

		function logic [DATA_W-1:0] mask_byte(logic [POS_W-1:0] pos);
			int unsigned len;
			int unsigned idx;
			len = key_len;
			if (len == 0)
				return '0;
			if (len > MASK_MAX)
				len = MASK_MAX;
			idx = pos % len;
			return mask_word[idx / 8][8 * (idx % 8) +: 8];
		endfunction

		function logic [DATA_W-1:0] pos_key(logic [POS_W-1:0] pos);
			return DATA_W'(pos + 1);
		endfunction

		function logic [POS_W-1:0] mirror_pos(logic [POS_W-1:0] i, logic [LEN_W-1:0] n);
			if (n > MIRROR_MIN && i >= 1)
				return POS_W'(n - i);
			return i;
		endfunction

		function scrambled_byte_t predict(logic [DATA_W-1:0] b, logic [POS_W-1:0] i,
				logic [LEN_W-1:0] n);
			scrambled_byte_t  r;
			logic [POS_W-1:0] p;
			r.out_byte = b;
			r.dest     = i;
			r.bad      = 1'b0;
			if (LEN_W'(i) >= n || n > PACKET_MAX) begin
				r.bad = 1'b1;
				return r;
			end
			p = mirror_pos(i, n);
			case (method)
				METHOD_MASK: r.out_byte = b ^ mask_byte(i);
				METHOD_XPOS: r.out_byte = b ^ pos_key(i);
				METHOD_REV:  r.dest = p;
				METHOD_OBF: begin
					r.dest = p;
					if (outbound)
						r.out_byte = b ^ pos_key(i) ^ pos_key(p) ^ mask_byte(p);
					else
						r.out_byte = b ^ mask_byte(i) ^ pos_key(i) ^ pos_key(p);
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_input(logic [DATA_W-1:0] b, logic [POS_W-1:0] i,
				logic [LEN_W-1:0] n);
			scrambled_byte_t r;
			r = predict(b, i, n);
			if (r.bad)
				flagged++;
			expected_q.push_back(r);
			accepted++;
		endfunction

		function void check_result(logic [DATA_W-1:0] b, logic [POS_W-1:0] d, logic bad);
			scrambled_byte_t r;
			checked++;
			if (expected_q.size() == 0) begin
				$error("result with no transaction outstanding: byte %0h dest %0d", b, d);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (b !== r.out_byte) begin
				$error("result_byte: expected %0h, got %0h", r.out_byte, b);
				errors++;
			end
			if (d !== r.dest) begin
				$error("dest_position: expected %0d, got %0d", r.dest, d);
				errors++;
			end
			if (bad !== r.bad) begin
				$error("bad_position: expected %0b, got %0b", r.bad, bad);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [REG_W-1:0]  pwdata;
	logic [REG_W-1:0]  prdata;
	logic              pready;
	logic              item_valid;
	logic              item_ready;
	logic [DATA_W-1:0] data_byte;
	logic [POS_W-1:0]  position;
	logic [LEN_W-1:0]  packet_length;
	logic              result_valid;
	logic              result_ready;
	logic [DATA_W-1:0] result_byte;
	logic [POS_W-1:0]  dest_position;
	logic              bad_position;

	scramble_scoreboard sb = new();
	int                 settings_used;
	int                 idle_cycles;
	bit                 hold_req;

	packet_xor_scramble dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.data_byte     (data_byte),
		.position      (position),
		.packet_length (packet_length),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_byte   (result_byte),
		.dest_position (dest_position),
		.bad_position  (bad_position)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int draw_gap();
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(0, 19);
		return 0;
	endfunction

	function automatic logic [REG_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				sb.note_input(data_byte, position, packet_length);
			if (result_valid && result_ready)
				sb.check_result(result_byte, dest_position, bad_position);
			if ((item_valid && item_ready) || (result_valid && result_ready)
					|| (psel && penable && pwrite && pready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = draw_gap();
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [REG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic set_config(logic [2:0] m, logic ob, logic [MLEN_W-1:0] len,
			logic [REG_W-1:0] w0, logic [REG_W-1:0] w1,
			logic [REG_W-1:0] w2, logic [REG_W-1:0] w3);
		reg_write(REG_METHOD, REG_W'(m));
		reg_write(REG_OUTBOUND, REG_W'(ob));
		reg_write(REG_KEY_LEN, REG_W'(len));
		reg_write(REG_MASK0, w0);
		reg_write(REG_MASK1, w1);
		reg_write(REG_MASK2, w2);
		reg_write(REG_MASK3, w3);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic send_byte(int b, int i, int n);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid    <= 1'b1;
		data_byte     <= DATA_W'(b);
		position      <= POS_W'(i);
		packet_length <= LEN_W'(n);
		do @(posedge clk); while (!(item_valid && item_ready));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic directed_mode(logic [2:0] m, logic ob);
		int n;
		drain();
		set_config(m, ob, MLEN_W'(7), rand64(), rand64(), rand64(), rand64());
		repeat (2) begin
			n = $urandom_range(3, 40);
			send_byte($urandom_range(0, 255), $urandom_range(0, n - 1), n);
		end
	endtask

	task automatic random_traffic(int count);
		int sent;
		int r;
		int n;
		int i;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				n = $urandom_range(1, 12);
				for (i = 0; i < n; i++)
					send_byte($urandom_range(0, 255), i, n);
				sent += n;
			end else if (r < 80) begin
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, PACKET_MAX)
				                                : $urandom_range(1, 200);
				send_byte($urandom_range(0, 255), $urandom_range(0, n - 1), n);
				sent++;
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						n = 0;
						i = $urandom_range(0, 2047);
					end
					1: begin
						n = $urandom_range(1, 2047);
						i = $urandom_range(n, 2047);
					end
					default: begin
						n = $urandom_range(PACKET_MAX + 1, 4095);
						i = $urandom_range(0, 2047);
					end
				endcase
				send_byte($urandom_range(0, 255), i, n);
				sent++;
			end
		end
	endtask

	initial begin
		logic [REG_W-1:0] ones;
		ones          = '1;
		sb.reset_regs();
		settings_used = 0;
		idle_cycles   = 0;
		hold_req      = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		item_valid    = 1'b0;
		data_byte     = '0;
		position      = '0;
		packet_length = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(METHOD_OBF, 1'b1, MLEN_W'(5), rand64(), rand64(), rand64(), rand64());
		send_byte(8'h00, 0, 1);
		send_byte(8'hff, 2047, 2048);
		send_byte(8'ha5, 0, 0);
		send_byte(8'h5a, 5, 4095);
		send_byte(8'h3c, 2047, 2047);
		send_byte(8'hc3, 1, 2);
		send_byte(8'h81, 1, 3);
		send_byte(8'h7e, 2, 3);
		send_byte(8'h12, 1000, 2048);
		send_byte(8'hff, 0, 2049);
		send_byte(8'h00, 2047, 4095);
		send_byte(8'h55, 0, 12);
		directed_mode(METHOD_PLAIN, 1'b0);
		directed_mode(METHOD_MASK, 1'b0);
		directed_mode(METHOD_XPOS, 1'b0);
		directed_mode(METHOD_REV, 1'b0);
		directed_mode(METHOD_OBF, 1'b0);
		directed_mode(METHOD_SPARE, 1'b1);

		drain();
		set_config(METHOD_MASK, 1'b0, MLEN_W'(MASK_MAX), ones, ones, ones, ones);
		random_traffic(PHASE_ITEMS);

		drain();
		set_config(METHOD_OBF, 1'b1, MLEN_W'(1), '0, '0, '0, '0);
		hold_req = 1'b1;
		random_traffic(PHASE_ITEMS);

		drain();
		set_config(METHOD_OBF, 1'b0, '1, rand64(), rand64(), rand64(), rand64());
		random_traffic(PHASE_ITEMS);

		drain();
		set_config(METHOD_MASK, 1'b0, '0, rand64(), rand64(), rand64(), rand64());
		random_traffic(PHASE_ITEMS);

		drain();
		set_config(METHOD_XPOS, 1'b1, MLEN_W'($urandom_range(1, MASK_MAX)),
			rand64(), rand64(), rand64(), rand64());
		random_traffic(PHASE_ITEMS / 2);
		drain();
		random_traffic(PHASE_ITEMS / 2);

		drain();
		set_config(METHOD_REV, 1'b0, MLEN_W'(17), rand64(), rand64(), rand64(), rand64());
		random_traffic(PHASE_ITEMS);

		drain();
		set_config(METHOD_OBF, 1'($urandom_range(0, 1)), MLEN_W'($urandom_range(1, MASK_MAX)),
			rand64(), rand64(), rand64(), rand64());
		random_traffic(PHASE_ITEMS);

		drain();
		set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
			MLEN_W'($urandom_range(0, 63)), rand64(), rand64(), rand64(), rand64());
		random_traffic(PHASE_ITEMS);

		drain();
		$display("Scrambled %0d bytes under %0d register settings, %0d results checked",
			sb.accepted, settings_used, sb.checked);
		$display("%0d bytes carried an out-of-range position; %0d mismatches seen",
			sb.flagged, sb.errors);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
